// ===== src/esel_pkg.sv =====
// package for the ecc syndrome error locator: types, syndrome table, lookup functions
`default_nettype none
package esel_pkg;

  localparam int unsigned SynWidth   = 32;
  localparam int unsigned BankWidth  = 4;
  localparam int unsigned SlotWidth  = 4;
  localparam int unsigned PosWidth   = 7;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxWidth   = $clog2(TableDepth);
  localparam int unsigned LowWidth   = 3;

  typedef logic [7:0] syn_byte_t;

  localparam syn_byte_t SYN_TABLE [TableDepth] = '{
    8'h13, 8'h23, 8'h43, 8'h83, 8'h2f, 8'hf1, 8'h0d, 8'h07,
    8'hd0, 8'h70, 8'h4f, 8'hf8, 8'h61, 8'h62, 8'h64, 8'h68,
    8'h1c, 8'h2c, 8'h4c, 8'h8c, 8'h15, 8'h25, 8'h45, 8'h85,
    8'h19, 8'h29, 8'h49, 8'h89, 8'h1a, 8'h2a, 8'h4a, 8'h8a,
    8'h51, 8'h52, 8'h54, 8'h58, 8'h91, 8'h92, 8'h94, 8'h98,
    8'ha1, 8'ha2, 8'ha4, 8'ha8, 8'h31, 8'h32, 8'h34, 8'h38,
    8'h16, 8'h26, 8'h46, 8'h86, 8'h1f, 8'hf2, 8'h0b, 8'h0e,
    8'hb0, 8'he0, 8'h8f, 8'hf4, 8'hc1, 8'hc2, 8'hc4, 8'hc8
  };

  // classification of one syndrome byte
  typedef struct packed {
    logic                multi;
    logic                hit;
    logic [IdxWidth-1:0] idx;
    logic [LowWidth-1:0] low;
  } classify_t;

  // first table entry that matches
  function automatic classify_t table_search(input syn_byte_t b);
    classify_t r;
    r = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (SYN_TABLE[i] == b) begin
        r.hit = 1'b1;
        r.idx = IdxWidth'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/esel_classify.sv =====
// syndrome byte classifier: weight test, table search, lowest set bit
`default_nettype none
module esel_classify
  import esel_pkg::*;
(
  input  var syn_byte_t byte_in,
  output var classify_t cls
);

  classify_t srch;
  logic [3:0] ones;
  logic [LowWidth-1:0] low;

  always_comb begin
    ones = '0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + {3'b000, byte_in[i]};
    end
  end

  always_comb begin
    low = '0;
    for (int i = 7; i >= 0; i--) begin
      if (byte_in[i]) begin
        low = LowWidth'(i);
      end
    end
  end

  assign srch = table_search(byte_in);

  always_comb begin
    cls       = srch;
    cls.multi = (ones > 4'd1);
    cls.low   = low;
  end

endmodule
`default_nettype wire

// ===== src/ecc_syndrome_error_locator.sv =====
// top level of the ecc syndrome error locator, a three-stage decode pipeline
// throughput: one transaction per cycle through the three-stage register pipeline while out_ready is high
// stages: byte select, byte classify and table search, position assembly
// reset: synchronous active-low rst_n clears all stage valid bits; no other state
`default_nettype none
module ecc_syndrome_error_locator
  import esel_pkg::*;
(
  input  var logic                        clk,
  input  var logic                        rst_n,
  input  var logic                        in_valid,
  output var logic                        in_ready,
  input  var logic [SynWidth-1:0]         in_syndrome,
  input  var logic signed [BankWidth-1:0] in_bank,
  input  var logic                        in_hard_error,
  output var logic                        out_valid,
  input  var logic                        out_ready,
  output var logic                        out_slot_known,
  output var logic [SlotWidth-1:0]        out_slot_number,
  output var logic                        out_back_side,
  output var logic                        out_bit_valid,
  output var logic                        out_is_data_bit,
  output var logic                        out_table_miss,
  output var logic [PosWidth-1:0]         out_bit_position
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: half and byte select, slot info
  logic           half;
  logic [15:0]    half_bits;
  logic           group_nxt;
  syn_byte_t      byte_nxt;
  logic [SlotWidth-1:0] slot_nxt;

  syn_byte_t      s1_byte_r;
  logic           s1_group_r, s1_hard_r, s1_known_r, s1_back_r;
  logic [SlotWidth-1:0] s1_slot_r;

  always_comb begin
    half      = (in_syndrome[15:0] == 16'h0000);
    half_bits = half ? in_syndrome[31:16] : in_syndrome[15:0];
    group_nxt = (half_bits != 16'h0000) && (half_bits[7:0] == 8'h00);
    byte_nxt  = group_nxt ? half_bits[15:8] : half_bits[7:0];
    slot_nxt  = in_bank[BankWidth-1] ? '0
              : ({1'b0, in_bank[2:1], 1'b0} + {3'b000, half} + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_byte_r  <= byte_nxt;
      s1_group_r <= group_nxt;
      s1_hard_r  <= in_hard_error;
      s1_known_r <= !in_bank[BankWidth-1];
      s1_back_r  <= in_bank[0];
      s1_slot_r  <= slot_nxt;
    end
  end

  // stage 2: classify the byte
  classify_t cls;

  esel_classify u_classify (
    .byte_in (s1_byte_r),
    .cls     (cls)
  );

  classify_t s2_cls_r;
  logic      s2_group_r, s2_hard_r, s2_known_r, s2_back_r;
  logic [SlotWidth-1:0] s2_slot_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_cls_r   <= cls;
      s2_group_r <= s1_group_r;
      s2_hard_r  <= s1_hard_r;
      s2_known_r <= s1_known_r;
      s2_back_r  <= s1_back_r;
      s2_slot_r  <= s1_slot_r;
    end
  end

  // stage 3: result assembly
  logic               bv_nxt, data_nxt, miss_nxt;
  logic [PosWidth-1:0] pos_nxt;

  always_comb begin
    bv_nxt   = !s2_hard_r;
    data_nxt = 1'b0;
    miss_nxt = 1'b0;
    pos_nxt  = '0;
    if (!s2_hard_r) begin
      if (s2_cls_r.multi) begin
        data_nxt = 1'b1;
        miss_nxt = !s2_cls_r.hit;
        pos_nxt  = s2_cls_r.hit ? {s2_group_r, s2_cls_r.idx} : '0;
      end else begin
        pos_nxt = {3'b000, s2_group_r, s2_cls_r.low};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      out_slot_known   <= s2_known_r;
      out_slot_number  <= s2_slot_r;
      out_back_side    <= s2_back_r;
      out_bit_valid    <= bv_nxt;
      out_is_data_bit  <= data_nxt;
      out_table_miss   <= miss_nxt;
      out_bit_position <= pos_nxt;
    end
  end

  assign out_valid = v3_r;

  a_unknown_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_slot_known) |-> (out_slot_number == '0))
    else $error("slot number set for unknown bank");

  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_miss) |-> (out_is_data_bit && out_bit_position == '0))
    else $error("table miss with position or check bit");

  a_hard_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bit_valid) |->
      (!out_is_data_bit && !out_table_miss && out_bit_position == '0))
    else $error("hard error reports a bit");

  a_known_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_slot_known) |->
      (out_slot_number != '0 && out_slot_number <= 4'd8))
    else $error("slot number out of range");

endmodule
`default_nettype wire
